@@ hw/rtl/rotary_encoder_decoder_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the rotary encoder decoder
// Shared wrappers around concurrent assertions. Defining ASSERT_OFF turns
// every use into nothing.
// ----------------------------------------------------------------------------
`ifndef ROTARY_ENCODER_DECODER_TOP_MACROS_SVH
`define ROTARY_ENCODER_DECODER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Checked at every rising clock edge, held off while reset is asserted.
`define RED_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked at every rising clock edge, reset included.
`define RED_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define RED_ASSERT(name, prop, msg)
`define RED_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

@@ hw/rtl/red_pkg.sv @@
// ----------------------------------------------------------------------------
// Rotary encoder decoder package
// Types shared by the top level and the per-sample update logic, and the
// quadrature transition table.
// ----------------------------------------------------------------------------
package red_pkg;

  localparam int unsigned IndexW    = 2;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned DebounceW = 16;
  localparam int unsigned InDataW   = 40;
  localparam int unsigned OutDataW  = 8;

  // One poll sample of one encoder.
  typedef struct packed {
    logic [TimeW-1:0]  time_ms;
    logic              switch_level;
    logic              pin_b_level;
    logic              pin_a_level;
    logic [IndexW-1:0] encoder_index;
  } sample_t;

  // Per-encoder state.
  typedef struct packed {
    logic [1:0]        last_ab;
    logic signed [2:0] quarter_steps;
    logic              stable_button;
    logic              last_raw_button;
    logic [TimeW-1:0]  change_stamp;
  } chan_t;

  localparam chan_t ChanReset = '{
    last_ab:         2'b11,
    quarter_steps:   3'sd0,
    stable_button:   1'b1,
    last_raw_button: 1'b1,
    change_stamp:    '0
  };

  // Events produced by one sample.
  typedef struct packed {
    logic button_pressed;
    logic button_event;
    logic rotate_direction;
    logic rotate_event;
  } events_t;

  // Quarter-step for the transition {previous A, previous B, A, B}.
  function automatic logic signed [1:0] quad_step(input logic [3:0] trans);
    logic signed [1:0] step;
    step = 2'sd0;
    case (trans) inside
      4'd2, 4'd4, 4'd11, 4'd13: step = 2'sd1;
      4'd1, 4'd7, 4'd8, 4'd14:  step = -2'sd1;
      default:                  step = 2'sd0;
    endcase
    return step;
  endfunction

endpackage

@@ hw/rtl/rotary_encoder_decoder_top.sv @@
// ----------------------------------------------------------------------------
// Rotary encoder decoder, top level
// Quadrature decoding and push-button debouncing for a bank of encoders.
// ----------------------------------------------------------------------------
// Each input word is one poll sample of one encoder: its index, the A, B and
// switch pin levels and a millisecond timestamp. Every sample yields exactly
// one output word with the index echoed and flags for a completed detent
// (with its direction) and a debounced button press or release. A word is
// accepted into an input register, decoded against that encoder's state in
// combinational logic, and the result lands in an output register, so a new
// word is taken every clock unless the result side stalls. The state of an
// encoder is written back as its word moves into the output register, which
// lets samples of the same encoder follow each other back to back.
// Samples whose index is not below ENCODER_COUNT leave all state alone and
// return a word with every event flag low. The debounce time register resets
// to 5 ms and should be written only while no words are in flight.
`include "rotary_encoder_decoder_top_macros.svh"

module rotary_encoder_decoder_top #(
  parameter int ENCODER_COUNT = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Debounce time in milliseconds.
  input  logic                            cfg_we_i,
  input  logic [red_pkg::DebounceW-1:0]   cfg_wdata_i,
  // Sample words.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [1:0] encoder_index, [2] pin_a_level, [3] pin_b_level,
  // [4] switch_level, [36:5] time_ms, [39:37] zero
  input  logic [red_pkg::InDataW-1:0]     s_axis_tdata,
  // Result words.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [1:0] source_index, [2] rotate_event, [3] rotate_direction,
  // [4] button_event, [5] button_pressed, [7:6] zero
  output logic [red_pkg::OutDataW-1:0]    m_axis_tdata
);
  import red_pkg::*;

  localparam int unsigned SelW = (ENCODER_COUNT > 1) ? $clog2(ENCODER_COUNT) : 1;

  logic [DebounceW-1:0] debounce_q;

  logic    in_valid_q;
  sample_t in_q;
  logic    out_valid_q;
  logic [IndexW-1:0] out_index_q;
  events_t out_events_q;

  chan_t chan_q [ENCODER_COUNT];

  logic            advance;
  logic            in_range;
  logic [SelW-1:0] sel;
  logic            update;
  chan_t           chan_cur;
  chan_t           chan_next;
  events_t         events;
  events_t         events_gated;

  // The output register moves when it is empty or being taken; the input
  // register refills whenever its word moves on.
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;

  assign in_range = int'(in_q.encoder_index) < ENCODER_COUNT;
  assign sel      = SelW'(in_q.encoder_index);
  assign update   = in_valid_q && advance && in_range;
  assign chan_cur = in_range ? chan_q[sel] : ChanReset;

  red_update u_update (
    .sample_i      (in_q),
    .chan_i        (chan_cur),
    .debounce_ms_i (debounce_q),
    .chan_o        (chan_next),
    .events_o      (events)
  );

  assign events_gated = in_range ? events : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DebounceW'(5);
    end else if (cfg_we_i) begin
      debounce_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q <= sample_t'(s_axis_tdata[IndexW+3+TimeW-1:0]);
    end
    if (advance && in_valid_q) begin
      out_index_q  <= in_q.encoder_index;
      out_events_q <= events_gated;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < ENCODER_COUNT; k++) begin
        chan_q[k] <= ChanReset;
      end
    end else if (update) begin
      chan_q[sel] <= chan_next;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_events_q, out_index_q};

  // A word held in the input register is never dropped while stalled.
  `RED_ASSERT(a_hold_in, in_valid_q && !advance |=> in_valid_q, "input word lost while stalled")
  // A detent always clears the count, so no stored count reaches a full step.
  `RED_ASSERT(a_count_range, update |-> chan_next.quarter_steps != -3'sd4, "count reached four")
  // Samples for absent encoders never carry events.
  `RED_ASSERT(a_no_event_out_of_range,
      m_axis_tvalid && int'(m_axis_tdata[IndexW-1:0]) >= ENCODER_COUNT
      |-> m_axis_tdata[5:2] == 4'b0000, "event for an absent encoder")
  // A button event leaves the debounced level matching the reported state.
  `RED_ASSERT(a_button_state, update && events.button_event
      |=> chan_q[$past(sel)].stable_button == !$past(events.button_pressed),
      "debounced level disagrees with button event")
  // Direction is only set together with a detent.
  `RED_ASSERT_ALWAYS(a_dir_with_event, !(m_axis_tvalid && out_events_q.rotate_direction &&
      !out_events_q.rotate_event) || !rst_ni, "direction without detent")

endmodule

@@ hw/rtl/red_update.sv @@
// ----------------------------------------------------------------------------
// Rotary encoder decoder, per-sample update
// Decodes one sample against the state of its encoder and returns the new
// state and the events.
// ----------------------------------------------------------------------------
module red_update (
  input  red_pkg::sample_t                  sample_i,
  input  red_pkg::chan_t                    chan_i,
  input  logic [red_pkg::DebounceW-1:0]     debounce_ms_i,
  output red_pkg::chan_t                    chan_o,
  output red_pkg::events_t                  events_o
);
  import red_pkg::*;

  logic [1:0]        ab;
  logic signed [1:0] step;
  logic signed [3:0] acc;
  logic [TimeW-1:0]  elapsed;

  assign ab      = {sample_i.pin_a_level, sample_i.pin_b_level};
  assign step    = quad_step({chan_i.last_ab, ab});
  assign acc     = 4'(chan_i.quarter_steps) + 4'(step);
  assign elapsed = sample_i.time_ms - chan_i.change_stamp;

  always_comb begin
    chan_o         = chan_i;
    events_o       = '0;
    chan_o.last_ab = ab;

    // A full detent clears the count; invalid transitions give no step.
    if (step != 2'sd0) begin
      if (acc == 4'sd4) begin
        chan_o.quarter_steps = 3'sd0;
        events_o.rotate_event = 1'b1;
      end else if (acc == -4'sd4) begin
        chan_o.quarter_steps = 3'sd0;
        events_o.rotate_event     = 1'b1;
        events_o.rotate_direction = 1'b1;
      end else begin
        chan_o.quarter_steps = acc[2:0];
      end
    end

    // A raw change restarts the timer; a held level that differs from the
    // debounced one is taken once it has been stable long enough.
    if (sample_i.switch_level != chan_i.last_raw_button) begin
      chan_o.last_raw_button = sample_i.switch_level;
      chan_o.change_stamp    = sample_i.time_ms;
    end else if (sample_i.switch_level != chan_i.stable_button &&
                 elapsed >= TimeW'(debounce_ms_i)) begin
      chan_o.stable_button    = sample_i.switch_level;
      events_o.button_event   = 1'b1;
      events_o.button_pressed = !sample_i.switch_level;
    end
  end

endmodule

@@ tb/sv/encoder_event_checker.sv @@
// ----------------------------------------------------------------------------
// Rotary encoder event checker
// Watches the sample and result channels, predicts the detent and button
// events for every accepted sample and compares them with the result words.
// ----------------------------------------------------------------------------
module encoder_event_checker #(
  parameter int ENCODER_COUNT = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [red_pkg::DebounceW-1:0] cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [red_pkg::InDataW-1:0]   s_axis_tdata,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [red_pkg::OutDataW-1:0]  m_axis_tdata,
  output int                            pending_o,
  output int                            mismatch_count_o
);

  localparam logic [red_pkg::DebounceW-1:0] DEBOUNCE_RESET_MS = 16'd5;

  // Quarter-step for the transition {previous A, previous B, A, B}.
  localparam logic signed [1:0] QUARTER_STEP [16] = '{
    2'sd0,  -2'sd1, 2'sd1,  2'sd0,
    2'sd1,  2'sd0,  2'sd0,  -2'sd1,
    -2'sd1, 2'sd0,  2'sd0,  2'sd1,
    2'sd0,  2'sd1,  -2'sd1, 2'sd0
  };

  typedef struct packed {
    logic [1:0]       pad;
    red_pkg::events_t events;
    logic [1:0]       source_index;
  } result_word_t;

  logic [red_pkg::DebounceW-1:0] debounce_ms;
  logic [1:0]                    prev_ab      [ENCODER_COUNT];
  logic signed [2:0]             step_acc     [ENCODER_COUNT];
  logic                          debounced    [ENCODER_COUNT];
  logic                          raw_level    [ENCODER_COUNT];
  logic [red_pkg::TimeW-1:0]     raw_stamp    [ENCODER_COUNT];

  result_word_t expected_events [$];
  result_word_t got;
  result_word_t want;
  int           mismatches;

  function automatic result_word_t predict_events(input red_pkg::sample_t smp);
    result_word_t              res;
    int                        i;
    int                        acc;
    logic [1:0]                ab;
    logic [red_pkg::TimeW-1:0] elapsed;
    res = '0;
    res.source_index = smp.encoder_index;
    i = int'(smp.encoder_index);
    if (i < ENCODER_COUNT) begin
      ab = {smp.pin_a_level, smp.pin_b_level};
      acc = int'(step_acc[i]) + int'(QUARTER_STEP[{prev_ab[i], ab}]);
      prev_ab[i] = ab;
      if (acc >= 4) begin
        acc = 0;
        res.events.rotate_event = 1'b1;
      end else if (acc <= -4) begin
        acc = 0;
        res.events.rotate_event     = 1'b1;
        res.events.rotate_direction = 1'b1;
      end
      step_acc[i] = 3'(acc);

      // Wrapping difference, so a timestamp rollover is harmless.
      elapsed = smp.time_ms - raw_stamp[i];
      if (smp.switch_level != raw_level[i]) begin
        raw_level[i] = smp.switch_level;
        raw_stamp[i] = smp.time_ms;
      end else if (smp.switch_level != debounced[i] &&
                   elapsed >= red_pkg::TimeW'(debounce_ms)) begin
        debounced[i] = smp.switch_level;
        res.events.button_event   = 1'b1;
        res.events.button_pressed = ~smp.switch_level;
      end
    end
    return res;
  endfunction

  function automatic void compare_field(input string field, input int want_v,
                                        input int got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, actual %0d", field, want_v, got_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_ms = DEBOUNCE_RESET_MS;
      for (int k = 0; k < ENCODER_COUNT; k++) begin
        prev_ab[k]   = 2'b11;
        step_acc[k]  = 3'sd0;
        debounced[k] = 1'b1;
        raw_level[k] = 1'b1;
        raw_stamp[k] = '0;
      end
      expected_events.delete();
      mismatches = 0;
      pending_o        <= 0;
      mismatch_count_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (expected_events.size() == 0) begin
          $error("result word with no sample outstanding: %h", m_axis_tdata);
          mismatches++;
        end else begin
          want = expected_events.pop_front();
          compare_field("source_index", int'(want.source_index),
                        int'(got.source_index));
          compare_field("rotate_event", int'(want.events.rotate_event),
                        int'(got.events.rotate_event));
          compare_field("rotate_direction", int'(want.events.rotate_direction),
                        int'(got.events.rotate_direction));
          compare_field("button_event", int'(want.events.button_event),
                        int'(got.events.button_event));
          compare_field("button_pressed", int'(want.events.button_pressed),
                        int'(got.events.button_pressed));
        end
      end
      if (cfg_we_i) begin
        debounce_ms = cfg_wdata_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_events.push_back(
            predict_events(red_pkg::sample_t'(s_axis_tdata[36:0])));
      end
      pending_o        <= expected_events.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// Rotary encoder decoder testbench
// Drives poll samples for all encoders through the decoder, with directed
// detent, glitch and debounce cases followed by random rotation and button
// activity under several debounce settings and handshake stall patterns.
// ----------------------------------------------------------------------------
module tb;

  localparam int ENCODER_COUNT   = 4;
  localparam int PHASE_COUNT     = 6;
  localparam int PHASE_SAMPLES   = 300;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 8;

  // Gray sequence that the decoder counts as clockwise, starting at rest.
  localparam logic [1:0] CW_SEQ [4] = '{2'b11, 2'b01, 2'b00, 2'b10};

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [red_pkg::DebounceW-1:0] cfg_wdata_i;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [red_pkg::InDataW-1:0]   s_axis_tdata;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [red_pkg::OutDataW-1:0]  m_axis_tdata;

  int pending_words;
  int mismatch_count;

  // Handshake pressure knobs, set by the stimulus process.
  int send_idle_pct;
  int recv_idle_pct;
  int hold_off_req;

  // What the stimulus last sent to each encoder, so that random sequences
  // continue from the pin state the decoder has stored.
  logic [1:0]                    sent_ab     [ENCODER_COUNT];
  logic                          sent_switch [ENCODER_COUNT];
  logic [red_pkg::TimeW-1:0]     now_ms;
  logic [red_pkg::DebounceW-1:0] debounce_ms;

  rotary_encoder_decoder_top #(
    .ENCODER_COUNT(ENCODER_COUNT)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  encoder_event_checker #(
    .ENCODER_COUNT(ENCODER_COUNT)
  ) event_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .pending_o       (pending_words),
    .mismatch_count_o(mismatch_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Offers one sample word and returns at the edge where it is taken. Before
  // the offer the sender may idle, as often as send_idle_pct draws; valid
  // stays high from one word to the next when there is no idle cycle in between.
  task automatic send_sample(input logic [1:0] enc, input logic [1:0] ab,
                             input logic sw, input logic [red_pkg::TimeW-1:0] t);
    red_pkg::sample_t smp;
    smp.encoder_index = enc;
    smp.pin_a_level   = ab[1];
    smp.pin_b_level   = ab[0];
    smp.switch_level  = sw;
    smp.time_ms       = t;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= red_pkg::InDataW'(smp);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent_ab[enc]     = ab;
    sent_switch[enc] = sw;
  endtask

  // The debounce register may only change with nothing in flight. The
  // idle edge first lets the checker count a word taken at the last edge.
  task automatic write_debounce(input logic [red_pkg::DebounceW-1:0] ms);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_words != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= ms;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    debounce_ms = ms;
  endtask

  // Mostly legal quadrature motion with a clockwise bias, so detents keep
  // completing, plus occasional double-pin glitches, button toggles and
  // time jumps sized to the current debounce window. A small share of words
  // is pure noise with random pins and timestamp.
  task automatic run_random_phase(input int count);
    int         n;
    int         k;
    int         pos;
    int         roll;
    logic [1:0] enc;
    logic [1:0] ab;
    logic       sw;
    for (n = 0; n < count; n++) begin
      enc = 2'($urandom_range(ENCODER_COUNT - 1));
      if ($urandom_range(99) < 8) begin
        send_sample(enc, 2'($urandom_range(3)), 1'($urandom_range(1)), $urandom);
      end else begin
        pos = 0;
        for (k = 0; k < 4; k++) begin
          if (CW_SEQ[k] == sent_ab[enc]) pos = k;
        end
        roll = $urandom_range(99);
        if (roll < 55) begin
          pos = (pos + 1) % 4;
        end else if (roll < 80) begin
          pos = (pos + 3) % 4;
        end else if (roll >= 92) begin
          pos = (pos + 2) % 4;
        end
        ab = CW_SEQ[pos];
        sw = sent_switch[enc];
        if ($urandom_range(99) < 6) sw = ~sw;
        if ($urandom_range(99) < 15) begin
          now_ms += $urandom_range(2 * int'(debounce_ms) + 2);
        end else begin
          now_ms += $urandom_range(3);
        end
        send_sample(enc, ab, sw, now_ms);
      end
    end
  endtask

  // Result side. A hold-off request keeps ready low for a long stretch so
  // that the decoder fills up and stalls the sample side.
  initial begin
    int hold_seen;
    int cyc;
    m_axis_tready = 1'b0;
    hold_seen = 0;
    forever begin
      @(posedge clk_i);
      if (hold_seen != hold_off_req) begin
        hold_seen = hold_off_req;
        m_axis_tready <= 1'b0;
        for (cyc = 0; cyc < HOLD_OFF_CYCLES; cyc++) @(posedge clk_i);
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    int phase;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    send_idle_pct = 35;
    recv_idle_pct = 53;
    hold_off_req  = 0;
    now_ms        = '0;
    debounce_ms   = 16'd5;
    for (int k = 0; k < ENCODER_COUNT; k++) begin
      sent_ab[k]     = 2'b11;
      sent_switch[k] = 1'b1;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, debounce at its reset value of 5 ms.
    // One clockwise detent on encoder 0, one counter-clockwise on encoder 1.
    send_sample(2'd0, 2'b01, 1'b1, 32'd10);
    send_sample(2'd0, 2'b00, 1'b1, 32'd11);
    send_sample(2'd0, 2'b10, 1'b1, 32'd12);
    send_sample(2'd0, 2'b11, 1'b1, 32'd13);
    send_sample(2'd1, 2'b10, 1'b1, 32'd14);
    send_sample(2'd1, 2'b00, 1'b1, 32'd15);
    send_sample(2'd1, 2'b01, 1'b1, 32'd16);
    send_sample(2'd1, 2'b11, 1'b1, 32'd17);
    // Both pins flipping at once counts no step.
    send_sample(2'd2, 2'b00, 1'b1, 32'd18);
    send_sample(2'd2, 2'b11, 1'b1, 32'd19);
    // Press on encoder 3: too early at 2 ms, accepted at exactly 5 ms, then
    // a release.
    send_sample(2'd3, 2'b11, 1'b0, 32'd100);
    send_sample(2'd3, 2'b11, 1'b0, 32'd102);
    send_sample(2'd3, 2'b11, 1'b0, 32'd105);
    send_sample(2'd3, 2'b11, 1'b1, 32'd106);
    send_sample(2'd3, 2'b11, 1'b1, 32'd200);
    // A bounce back to the debounced level gives no event.
    send_sample(2'd2, 2'b11, 1'b0, 32'd300);
    send_sample(2'd2, 2'b11, 1'b1, 32'd301);
    send_sample(2'd2, 2'b11, 1'b1, 32'd400);
    // Elapsed time across the timestamp rollover.
    send_sample(2'd0, 2'b11, 1'b0, 32'hFFFF_FFFE);
    send_sample(2'd0, 2'b11, 1'b0, 32'h0000_0003);
    // Zero debounce: the first repeat of a new level is accepted.
    write_debounce(16'd0);
    send_sample(2'd1, 2'b11, 1'b0, 32'hFFFF_FFFF);
    send_sample(2'd1, 2'b11, 1'b0, 32'hFFFF_FFFF);
    send_sample(2'd1, 2'b11, 1'b1, 32'd0);
    send_sample(2'd1, 2'b11, 1'b1, 32'd0);

    // Random part: each phase has its own debounce setting and stall pattern.
    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0:       write_debounce(16'd0);
        1:       write_debounce(16'hFFFF);
        2:       write_debounce(16'd5);
        3:       write_debounce(16'($urandom));
        4:       write_debounce(16'd1);
        default: write_debounce(16'($urandom_range(40)));
      endcase
      if (phase < 2) begin
        send_idle_pct = 35;
        recv_idle_pct = 53;
      end else if (phase < 4) begin
        send_idle_pct = 53;
        recv_idle_pct = 35;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (phase == 2) now_ms = 32'hFFFF_FF00;
      if (phase == 1 || phase == 4) hold_off_req++;
      run_random_phase(PHASE_SAMPLES);
    end

    // Drain: wait for every outstanding result, then keep the clock running so a
    // stray extra word would still be caught.
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_words != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/red_pkg.sv
hw/rtl/red_update.sv
hw/rtl/rotary_encoder_decoder_top.sv
tb/sv/encoder_event_checker.sv
tb/sv/tb.sv
